/* design/afe_pkg.sv */
// Shared types and constants of the API frame encoder.
`default_nettype none

package afe_pkg;

	// Item codes on the func input
	localparam logic FUNC_HEADER = 1'b0;
	localparam logic FUNC_DATA   = 1'b1;

	// Frame kinds carried by a header request
	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_LOCAL  = 2'd1,
		KIND_REMOTE = 2'd2,
		KIND_BAD    = 2'd3
	} frame_kind_t;

	// Frame bytes and codes
	localparam logic [7:0] START_DELIM = 8'h7E;
	localparam logic [7:0] TYPE_TX     = 8'h10;
	localparam logic [7:0] TYPE_LOCAL  = 8'h08;
	localparam logic [7:0] TYPE_REMOTE = 8'h17;
	localparam logic [7:0] FID_FIRST   = 8'h01;
	localparam logic [7:0] FID_LAST    = 8'hFF;
	localparam int         OPT_CRYPT   = 1;

	// Length field offsets over the payload length
	localparam logic [15:0] LEN_TX     = 16'd14;
	localparam logic [15:0] LEN_LOCAL  = 16'd4;
	localparam logic [15:0] LEN_REMOTE = 16'd15;

	// Header bytes before the checksum slot, per kind
	localparam int          IDX_W       = 5;
	localparam logic [4:0]  BODY_TX     = 5'd17;
	localparam logic [4:0]  BODY_LOCAL  = 5'd7;
	localparam logic [4:0]  BODY_REMOTE = 5'd18;
	localparam logic [4:0]  SUM_FIRST   = 5'd3;
	localparam int          MAX_RESULTS = 19;

	localparam int PLEN_W = 9;

	// Work queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [1:0] {
		JOB_HDR  = 2'd0,
		JOB_DATA = 2'd1,
		JOB_ERR  = 2'd2
	} job_op_t;

	typedef struct packed {
		job_op_t            op;
		frame_kind_t        kind;
		logic [PLEN_W-1:0]  plen;
		logic [7:0]         fid;
		logic [63:0]        a64;
		logic [15:0]        a16;
		logic [7:0]         bcr;
		logic [7:0]         opt;
		logic [15:0]        cmd;
		logic [7:0]         data;
		logic               last;
	} job_t;

endpackage

`default_nettype wire

/* design/afe_front.sv */
// Front part: classifies requests, tracks frame state and issues work jobs.
`default_nettype none

module afe_front import afe_pkg::*; #(
	parameter int MAX_PAYLOAD    = 256,
	parameter int CRYPT_OVERHEAD = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              func,
	input  wire logic [1:0]        frame_kind,
	input  wire logic [PLEN_W-1:0] payload_length,
	input  wire logic [63:0]       dest_addr64,
	input  wire logic [15:0]       dest_addr16,
	input  wire logic [7:0]        broadcast_radius,
	input  wire logic [7:0]        tx_options,
	input  wire logic [15:0]       at_command,
	input  wire logic [7:0]        data_byte,
	output job_t                   job,
	output logic                   job_valid
);

	localparam int LIMIT_PLAIN = MAX_PAYLOAD;
	localparam int LIMIT_CRYPT = MAX_PAYLOAD - CRYPT_OVERHEAD;
	localparam int LIM_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int CMP_W       = (LIM_W > PLEN_W) ? LIM_W : PLEN_W;

	logic [7:0]        fid_q;
	logic [PLEN_W-1:0] rem_q;
	logic              drop_q;
	frame_kind_t       kind;
	logic              too_big;
	logic [PLEN_W-1:0] rem_dec;

	assign kind    = frame_kind_t'(frame_kind);
	assign rem_dec = rem_q - PLEN_W'(1);
	assign too_big = tx_options[OPT_CRYPT]
		? (CMP_W'(payload_length) > CMP_W'(LIMIT_CRYPT))
		: (CMP_W'(payload_length) > CMP_W'(LIMIT_PLAIN));

	// Build the job for the current request
	always_comb begin
		job.op   = JOB_DATA;
		job.kind = kind;
		job.plen = payload_length;
		job.fid  = fid_q;
		job.a64  = dest_addr64;
		job.a16  = dest_addr16;
		job.bcr  = broadcast_radius;
		job.opt  = tx_options;
		job.cmd  = at_command;
		job.data = data_byte;
		job.last = (rem_q == PLEN_W'(1));
		job_valid = 1'b0;
		if (func == FUNC_DATA) begin
			job_valid = (rem_q != '0) && !drop_q;
		end else begin
			unique case (kind)
				KIND_BAD: job_valid = 1'b0;
				KIND_TX: begin
					job_valid = 1'b1;
					job.op    = too_big ? JOB_ERR : JOB_HDR;
				end
				default: begin
					job_valid = 1'b1;
					job.op    = JOB_HDR;
				end
			endcase
		end
	end

	// Advance frame state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fid_q  <= FID_FIRST;
			rem_q  <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (func == FUNC_DATA) begin
				if (rem_q != '0) begin
					rem_q <= rem_dec;
					if (drop_q && rem_dec == '0) begin
						drop_q <= 1'b0;
					end
				end
			end else if (kind != KIND_BAD) begin
				rem_q <= payload_length;
				if (kind == KIND_TX && too_big) begin
					drop_q <= (payload_length != '0);
				end else begin
					drop_q <= 1'b0;
					fid_q  <= (fid_q == FID_LAST) ? FID_FIRST : fid_q + 8'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* design/afe_fifo.sv */
// Short job queue that decouples the front part from the back part.
`default_nettype none

module afe_fifo import afe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      wdata,
	output logic      full,
	input  wire logic pop,
	output job_t      rdata,
	output logic      empty
);

	job_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule

`default_nettype wire

/* design/afe_back.sv */
// Back part: serialises jobs into frame bytes and keeps the checksum.
`default_nettype none

module afe_back import afe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      job,
	input  wire logic job_avail,
	output logic      job_pop,
	output logic [7:0] frame_byte,
	output logic      frame_end,
	output logic      oversize_error,
	output logic      run_last,
	output logic      empty,
	input  wire logic pop
);

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             end_q;
	logic             err_q;
	logic             last_q;

	logic [7:0]       seq [32];
	logic [IDX_W-1:0] body_n;
	logic [15:0]      len;
	logic [7:0]       ftype;
	logic             load;
	logic             work;
	logic [7:0]       cur_byte;
	logic             cur_end;
	logic             cur_err;
	logic             cur_done;
	logic             cur_sum;
	logic             sum_restart;

	assign load = !out_valid_q || pop;
	assign work = job_avail && load;

	// Lay out the header bytes of the frame kind
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			seq[i] = '0;
		end
		unique case (job.kind)
			KIND_TX: begin
				len    = LEN_TX + 16'(job.plen);
				ftype  = TYPE_TX;
				body_n = BODY_TX;
			end
			KIND_LOCAL: begin
				len    = LEN_LOCAL + 16'(job.plen);
				ftype  = TYPE_LOCAL;
				body_n = BODY_LOCAL;
			end
			default: begin
				len    = LEN_REMOTE + 16'(job.plen);
				ftype  = TYPE_REMOTE;
				body_n = BODY_REMOTE;
			end
		endcase
		seq[0] = START_DELIM;
		seq[1] = len[15:8];
		seq[2] = len[7:0];
		seq[3] = ftype;
		seq[4] = job.fid;
		if (job.kind == KIND_LOCAL) begin
			seq[5] = job.cmd[15:8];
			seq[6] = job.cmd[7:0];
		end else begin
			for (int i = 0; i < 8; i++) begin
				seq[5 + i] = job.a64[8 * (7 - i) +: 8];
			end
			seq[13] = job.a16[15:8];
			seq[14] = job.a16[7:0];
			if (job.kind == KIND_TX) begin
				seq[15] = job.bcr;
				seq[16] = job.opt;
			end else begin
				seq[15] = job.opt;
				seq[16] = job.cmd[15:8];
				seq[17] = job.cmd[7:0];
			end
		end
	end

	// Pick the byte for the current step of the job
	always_comb begin
		cur_byte    = '0;
		cur_end     = 1'b0;
		cur_err     = 1'b0;
		cur_done    = 1'b1;
		cur_sum     = 1'b0;
		sum_restart = 1'b0;
		unique case (job.op)
			JOB_HDR: begin
				if (idx_q == body_n) begin
					cur_byte = ~sum_q;
					cur_end  = 1'b1;
				end else begin
					cur_byte    = seq[idx_q];
					cur_sum     = (idx_q >= SUM_FIRST);
					sum_restart = (idx_q == SUM_FIRST);
					cur_done    = (idx_q == body_n - IDX_W'(1)) && (job.plen != '0);
				end
			end
			JOB_DATA: begin
				if (idx_q == '0) begin
					cur_byte = job.data;
					cur_sum  = 1'b1;
					cur_done = !job.last;
				end else begin
					cur_byte = ~sum_q;
					cur_end  = 1'b1;
				end
			end
			JOB_ERR: begin
				cur_err = 1'b1;
			end
			default: begin
				cur_done = 1'b1;
			end
		endcase
	end

	assign job_pop = work && cur_done;

	// Hold the step index and the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (work) begin
			idx_q <= cur_done ? '0 : idx_q + IDX_W'(1);
			if (cur_sum) begin
				sum_q <= sum_restart ? cur_byte : sum_q + cur_byte;
			end
		end
	end

	// Output stage: load a new byte when free or when the current one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= job_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			byte_q <= cur_byte;
			end_q  <= cur_end;
			err_q  <= cur_err;
			last_q <= cur_done;
		end
	end

	assign frame_byte     = byte_q;
	assign frame_end      = end_q;
	assign oversize_error = err_q;
	assign run_last       = last_q;
	assign empty          = !out_valid_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && end_q |-> last_q)
		else $error("checksum byte not marked as last of its request");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q |-> byte_q == '0 && last_q && !end_q)
		else $error("oversize result malformed");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(MAX_RESULTS))
		else $error("header step index out of range");

endmodule

`default_nettype wire

/* design/api_frame_encoder_top.sv */
// Top level of the API frame encoder: front, job queue and back.
//
// Input channel: a request is taken at a rising edge with push high and full
// low. A header request (func = 0) opens a frame of the given kind; payload
// requests (func = 1) carry one byte each. Result channel: while empty is low
// the oldest frame byte sits on frame_byte with its flags, and it leaves at a
// rising edge with pop high. run_last marks the last byte of each request.
// When the queue and back part are idle, the first byte of a request is written
// into the job queue, then into the output register, and can leave at the next edge.
// Throughput: while the receiver keeps popping, payload bytes flow at one per
// cycle; a header produces 7 to 19 bytes (a rejected oversize transmit header
// gives a single byte), one per cycle from the back part, while the front keeps
// taking requests until the four-entry job queue fills, so full is raised
// during header bursts. Requests that produce no byte (stray or dropped
// payload, unknown kind) never enter the queue.
// A stalled receiver holds the output byte; the queue then fills and full
// stalls the sender. Reset empties the queue and output stage, clears the
// checksum and payload count, and sets the frame id to one.
`default_nettype none

module api_frame_encoder_top import afe_pkg::*; #(
	parameter int MAX_PAYLOAD    = 256,
	parameter int CRYPT_OVERHEAD = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              func,
	input  wire logic [1:0]        frame_kind,
	input  wire logic [PLEN_W-1:0] payload_length,
	input  wire logic [63:0]       dest_addr64,
	input  wire logic [15:0]       dest_addr16,
	input  wire logic [7:0]        broadcast_radius,
	input  wire logic [7:0]        tx_options,
	input  wire logic [15:0]       at_command,
	input  wire logic [7:0]        data_byte,
	output logic                   empty,
	input  wire logic              pop,
	output logic [7:0]             frame_byte,
	output logic                   frame_end,
	output logic                   oversize_error,
	output logic                   run_last
);

	logic accept;
	job_t front_job;
	logic front_valid;
	job_t queue_job;
	logic queue_empty;
	logic queue_full;
	logic back_pop;

	assign full   = queue_full;
	assign accept = push && !queue_full;

	afe_front #(
		.MAX_PAYLOAD    (MAX_PAYLOAD),
		.CRYPT_OVERHEAD (CRYPT_OVERHEAD)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.func             (func),
		.frame_kind       (frame_kind),
		.payload_length   (payload_length),
		.dest_addr64      (dest_addr64),
		.dest_addr16      (dest_addr16),
		.broadcast_radius (broadcast_radius),
		.tx_options       (tx_options),
		.at_command       (at_command),
		.data_byte        (data_byte),
		.job              (front_job),
		.job_valid        (front_valid)
	);

	afe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && front_valid),
		.wdata  (front_job),
		.full   (queue_full),
		.pop    (back_pop),
		.rdata  (queue_job),
		.empty  (queue_empty)
	);

	afe_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (queue_job),
		.job_avail      (!queue_empty),
		.job_pop        (back_pop),
		.frame_byte     (frame_byte),
		.frame_end      (frame_end),
		.oversize_error (oversize_error),
		.run_last       (run_last),
		.empty          (empty),
		.pop            (pop)
	);

endmodule

`default_nettype wire

/* tb/sv/api_frame_encoder_top_test.sv */
// Self-checking testbench of the API frame encoder top level.
module api_frame_encoder_top_test;
	import afe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAYLOAD    = 256;
	localparam int CRYPT_OVERHEAD = 4;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_ITEMS   = 10;

	// One request on the input side
	typedef struct {
		logic              func;
		frame_kind_t       kind;
		logic [PLEN_W-1:0] plen;
		logic [63:0]       a64;
		logic [15:0]       a16;
		logic [7:0]        bcr;
		logic [7:0]        opt;
		logic [15:0]       cmd;
		logic [7:0]        data;
	} request_t;

	// One frame byte with its flags
	typedef struct {
		logic [7:0] fbyte;
		logic       fend;
		logic       ferr;
		logic       flast;
	} frame_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              func = FUNC_HEADER;
	logic [1:0]        frame_kind = KIND_TX;
	logic [PLEN_W-1:0] payload_length = '0;
	logic [63:0]       dest_addr64 = '0;
	logic [15:0]       dest_addr16 = '0;
	logic [7:0]        broadcast_radius = '0;
	logic [7:0]        tx_options = '0;
	logic [15:0]       at_command = '0;
	logic [7:0]        data_byte = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [7:0]        frame_byte;
	logic              frame_end;
	logic              oversize_error;
	logic              run_last;

	// Encoder state as predicted
	logic [7:0]        fid_next = FID_FIRST;
	logic [PLEN_W-1:0] payload_left = '0;
	logic [7:0]        sum_acc = '0;
	logic              dropping = 1'b0;
	frame_out_t        frame_bytes_due[$];

	int errors = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_ticket = 0;
	int hold_taken = 0;
	int hold_left = 0;

	api_frame_encoder_top #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.CRYPT_OVERHEAD(CRYPT_OVERHEAD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.frame_kind(frame_kind),
		.payload_length(payload_length),
		.dest_addr64(dest_addr64),
		.dest_addr16(dest_addr16),
		.broadcast_radius(broadcast_radius),
		.tx_options(tx_options),
		.at_command(at_command),
		.data_byte(data_byte),
		.empty(empty),
		.pop(pop),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.oversize_error(oversize_error),
		.run_last(run_last)
	);

	always #10 clk = ~clk;

	// Append one frame byte, adding it to the checksum where it counts
	function automatic void put_byte(ref frame_out_t q[$], input logic [7:0] b,
			input bit summed);
		if (summed)
			sum_acc = sum_acc + b;
		q = {q, frame_out_t'{b, 1'b0, 1'b0, 1'b0}};
	endfunction

	// Work out the frame bytes that one accepted request causes
	task automatic encode_request(input request_t r);
		frame_out_t outq[$];
		logic [15:0] flen;
		logic [7:0]  ftype;
		int          limit;
		int          i;
		if (r.func == FUNC_DATA) begin
			if (payload_left == 0)
				return;
			payload_left = payload_left - 1'b1;
			if (dropping) begin
				if (payload_left == 0)
					dropping = 1'b0;
				return;
			end
			put_byte(outq, r.data, 1'b1);
			if (payload_left == 0)
				outq = {outq, frame_out_t'{8'(8'hFF - sum_acc), 1'b1, 1'b0, 1'b0}};
		end else begin
			if (r.kind == KIND_BAD)
				return;
			limit = MAX_PAYLOAD - (r.opt[OPT_CRYPT] ? CRYPT_OVERHEAD : 0);
			if (r.kind == KIND_TX && int'(r.plen) > limit) begin
				// Reject the frame and swallow its payload
				payload_left = r.plen;
				dropping = (r.plen != 0);
				sum_acc = '0;
				outq = {outq, frame_out_t'{8'h00, 1'b0, 1'b1, 1'b0}};
			end else begin
				case (r.kind)
				KIND_TX: begin
					flen = LEN_TX + r.plen;
					ftype = TYPE_TX;
				end
				KIND_LOCAL: begin
					flen = LEN_LOCAL + r.plen;
					ftype = TYPE_LOCAL;
				end
				default: begin
					flen = LEN_REMOTE + r.plen;
					ftype = TYPE_REMOTE;
				end
				endcase
				dropping = 1'b0;
				payload_left = r.plen;
				sum_acc = '0;
				put_byte(outq, START_DELIM, 1'b0);
				put_byte(outq, flen[15:8], 1'b0);
				put_byte(outq, flen[7:0], 1'b0);
				put_byte(outq, ftype, 1'b1);
				put_byte(outq, fid_next, 1'b1);
				fid_next = (fid_next == FID_LAST) ? FID_FIRST : fid_next + 8'd1;
				if (r.kind != KIND_LOCAL) begin
					for (i = 7; i >= 0; i--)
						put_byte(outq, r.a64[8*i +: 8], 1'b1);
					put_byte(outq, r.a16[15:8], 1'b1);
					put_byte(outq, r.a16[7:0], 1'b1);
				end
				if (r.kind == KIND_TX) begin
					put_byte(outq, r.bcr, 1'b1);
					put_byte(outq, r.opt, 1'b1);
				end else begin
					if (r.kind == KIND_REMOTE)
						put_byte(outq, r.opt, 1'b1);
					put_byte(outq, r.cmd[15:8], 1'b1);
					put_byte(outq, r.cmd[7:0], 1'b1);
				end
				if (r.plen == 0)
					outq = {outq, frame_out_t'{8'(8'hFF - sum_acc), 1'b1, 1'b0, 1'b0}};
			end
		end
		outq[outq.size()-1].flast = 1'b1;
		frame_bytes_due = {frame_bytes_due, outq};
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: %s mismatch, got %02h expected %02h", $time, what, got, want);
		errors++;
	endtask

	// Compare each popped byte with the oldest one due
	always @(posedge clk) begin
		frame_out_t want;
		if (arst_n && pop && !empty) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch("unexpected byte", frame_byte, 8'h00);
			end else begin
				want = frame_bytes_due.pop_front();
				if (frame_byte !== want.fbyte)
					report_mismatch("frame_byte", frame_byte, want.fbyte);
				if (frame_end !== want.fend)
					report_mismatch("frame_end", 8'(frame_end), 8'(want.fend));
				if (oversize_error !== want.ferr)
					report_mismatch("oversize_error", 8'(oversize_error), 8'(want.ferr));
				if (run_last !== want.flast)
					report_mismatch("run_last", 8'(run_last), 8'(want.flast));
			end
		end
	end

	// Drive pop: random idling, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_taken != hold_ticket) begin
			hold_taken <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	function automatic request_t random_request(input logic f, input frame_kind_t k,
			input int n);
		request_t r;
		r.func = f;
		r.kind = k;
		r.plen = PLEN_W'(n);
		r.a64 = {$urandom, $urandom};
		r.a16 = 16'($urandom);
		r.bcr = 8'($urandom);
		r.opt = 8'($urandom);
		r.cmd = 16'($urandom);
		r.data = 8'($urandom);
		return r;
	endfunction

	// Offer one request, hold it until taken, then predict its bytes
	task automatic send_request(input request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		func = r.func;
		frame_kind = r.kind;
		payload_length = r.plen;
		dest_addr64 = r.a64;
		dest_addr16 = r.a16;
		broadcast_radius = r.bcr;
		tx_options = r.opt;
		at_command = r.cmd;
		data_byte = r.data;
		push = 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		encode_request(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_payload(input int n);
		repeat (n)
			send_request(random_request(FUNC_DATA, frame_kind_t'($urandom_range(3)),
				$urandom_range(511)));
	endtask

	// Header alone with random fields but the given options
	task automatic send_header(input frame_kind_t k, input int n, input logic [7:0] opt);
		request_t r;
		r = random_request(FUNC_HEADER, k, n);
		r.opt = opt;
		send_request(r);
	endtask

	// Header with random fields but the given options, then its payload
	task automatic send_frame(input frame_kind_t k, input int n, input logic [7:0] opt);
		send_header(k, n, opt);
		send_payload(n);
	endtask

	task automatic wait_drain;
		push = 1'b0;
		while (frame_bytes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// All three kinds with field extremes
	task automatic test_frame_kinds;
		request_t r;
		r = random_request(FUNC_HEADER, KIND_TX, 2);
		r.a64 = '1;
		r.a16 = '1;
		r.bcr = '1;
		r.opt = '1;
		send_request(r);
		r = random_request(FUNC_DATA, KIND_TX, 0);
		r.data = 8'hFF;
		send_request(r);
		r.data = 8'h00;
		send_request(r);
		r = random_request(FUNC_HEADER, KIND_LOCAL, 1);
		r.cmd = '1;
		send_request(r);
		send_payload(1);
		r = random_request(FUNC_HEADER, KIND_REMOTE, 3);
		r.a64 = '0;
		r.a16 = '0;
		r.opt = '0;
		r.cmd = '0;
		send_request(r);
		send_payload(3);
	endtask

	// Checksum straight after the header
	task automatic test_empty_payload;
		send_frame(KIND_TX, 0, 8'h00);
		send_frame(KIND_LOCAL, 0, 8'h5A);
		send_frame(KIND_REMOTE, 0, 8'hA5);
	endtask

	// New header cuts an unfinished frame short
	task automatic test_frame_abandon;
		send_frame(KIND_TX, 0, 8'h00);
		send_request(random_request(FUNC_HEADER, KIND_TX, 5));
		send_payload(2);
		send_frame(KIND_LOCAL, 0, 8'h00);
		send_request(random_request(FUNC_HEADER, KIND_REMOTE, 4));
		send_payload(1);
		send_frame(KIND_REMOTE, 1, 8'h02);
	endtask

	// Unknown kind and stray payload change nothing
	task automatic test_ignored_requests;
		send_request(random_request(FUNC_HEADER, KIND_BAD, 3));
		send_payload(2);
		send_request(random_request(FUNC_HEADER, KIND_LOCAL, 2));
		send_payload(1);
		send_request(random_request(FUNC_HEADER, KIND_BAD, 0));
		send_payload(1);
		send_payload(1);
	endtask

	// Length limits of transmit frames, with and without encryption
	task automatic test_oversize;
		// Encrypted transmit one over its limit: rejected, payload dropped
		send_header(KIND_TX, 253, 8'h02);
		send_payload(2);
		// Encrypted transmit right at its limit is framed
		send_header(KIND_TX, 252, 8'h02);
		send_payload(2);
		send_header(KIND_TX, 256, 8'hFD);
		send_payload(1);
		send_header(KIND_TX, 256, 8'hFF);
		send_payload(1);
		// Length beyond the usual range
		send_header(KIND_TX, 300, 8'h00);
		send_payload(1);
		// Commands carry no limit
		send_header(KIND_REMOTE, 256, 8'h02);
		send_payload(1);
		send_header(KIND_LOCAL, 256, 8'hFF);
		send_payload(1);
		send_frame(KIND_REMOTE, 1, 8'h00);
	endtask

	// Run the frame id past its top value
	task automatic test_frame_id_wrap;
		while (fid_next != FID_LAST)
			send_frame(frame_kind_t'($urandom_range(2)), 0, 8'($urandom));
		repeat (2)
			send_frame(frame_kind_t'($urandom_range(2)), 0, 8'($urandom));
	endtask

	// Stall the receiver long enough for full to push back on the sender
	task automatic test_backpressure;
		hold_ticket <= hold_ticket + 1;
		send_frame(KIND_TX, 8, 8'h00);
		send_frame(KIND_REMOTE, 3, 8'h00);
	endtask

	// Mostly well-formed frames with random content, some noise
	task automatic test_random_traffic(input int n_items);
		int start;
		int pick;
		int n;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				n = $urandom_range(6);
				send_frame(frame_kind_t'($urandom_range(2)), n, 8'($urandom));
			end else if (pick < 83) begin
				n = $urandom_range(10, 3);
				send_frame(frame_kind_t'($urandom_range(2)), 0, 8'($urandom));
				send_request(random_request(FUNC_HEADER,
					frame_kind_t'($urandom_range(2)), n));
				send_payload($urandom_range(n - 1));
			end else if (pick < 89) begin
				send_payload($urandom_range(3, 1));
			end else if (pick < 94) begin
				send_request(random_request(FUNC_HEADER, KIND_BAD, $urandom_range(511)));
			end else begin
				send_header(KIND_TX, $urandom_range(256, 253), 8'($urandom) | 8'h02);
				send_payload($urandom_range(4));
			end
		end
	endtask

	initial begin
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_idling(16, 60);
		test_frame_kinds;
		test_empty_payload;
		test_frame_abandon;
		test_ignored_requests;
		test_oversize;
		test_backpressure;
		test_random_traffic(RANDOM_ITEMS);

		set_idling(60, 16);
		test_random_traffic(RANDOM_ITEMS);

		set_idling(0, 0);
		test_random_traffic(RANDOM_ITEMS);
		test_frame_id_wrap;

		wait_drain;
		if (errors == 0)
			$display("api_frame_encoder_top verification clean");
		else
			$display("api_frame_encoder_top verification failed");
		$finish;
	end

	// Stop a run that hangs
	initial begin
		#(20 * 300_000);
		$display("api_frame_encoder_top verification failed");
		$finish;
	end

endmodule

/* sim.f */
design/afe_pkg.sv
design/afe_front.sv
design/afe_fifo.sv
design/afe_back.sv
design/api_frame_encoder_top.sv
tb/sv/api_frame_encoder_top_test.sv
